### sv/gpio_expander_edge_interrupt_top_defines.svh
// Assertion macros for the GPIO expander top level.
// Expects clk and rst in the scope of use.
`ifndef GPIO_EXPANDER_EDGE_INTERRUPT_TOP_DEFINES_SVH
`define GPIO_EXPANDER_EDGE_INTERRUPT_TOP_DEFINES_SVH

// same-cycle implication
`define GPIOE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GPIOE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/gpioe_pkg.sv
// Shared types and constants for the GPIO expander block.
// No dependencies.
package gpioe_pkg;

  localparam int unsigned NUM_PINS_DEFAULT = 16;
  localparam int unsigned PIN_WIDTH        = 16;

  typedef logic [1:0] op_t;
  localparam op_t OP_SAMPLE = 2'd0;
  localparam op_t OP_WRITE  = 2'd1;
  localparam op_t OP_READ   = 2'd2;

  typedef logic [6:0] addr_t;
  localparam addr_t ADDR_PULLUP_B  = 7'h06;
  localparam addr_t ADDR_PULLUP_A  = 7'h07;
  localparam addr_t ADDR_DIR_B     = 7'h0e;
  localparam addr_t ADDR_DIR_A     = 7'h0f;
  localparam addr_t ADDR_DATA_B    = 7'h10;
  localparam addr_t ADDR_DATA_A    = 7'h11;
  localparam addr_t ADDR_MASK_B    = 7'h12;
  localparam addr_t ADDR_MASK_A    = 7'h13;
  localparam addr_t ADDR_SENSE_3   = 7'h14;
  localparam addr_t ADDR_SENSE_2   = 7'h15;
  localparam addr_t ADDR_SENSE_1   = 7'h16;
  localparam addr_t ADDR_SENSE_0   = 7'h17;
  localparam addr_t ADDR_SOURCE_B  = 7'h18;
  localparam addr_t ADDR_SOURCE_A  = 7'h19;
  localparam addr_t ADDR_EVENT_B   = 7'h1a;
  localparam addr_t ADDR_EVENT_A   = 7'h1b;
  localparam addr_t ADDR_RESET     = 7'h7d;

  localparam logic [7:0] RESET_KEY1 = 8'h12;
  localparam logic [7:0] RESET_KEY2 = 8'h34;

  typedef logic [PIN_WIDTH-1:0] pins_t;

  typedef struct packed {
    op_t        operation;
    addr_t      reg_address;
    logic [7:0] write_byte;
    pins_t      pin_levels;
  } item_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       irq_active;
    pins_t      drive_enable;
    pins_t      drive_level;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### sv/gpioe_if.sv
// Handshake channel interfaces for the GPIO expander.
// Depends on gpioe_pkg.
interface gpioe_req_if;
  logic               valid;
  logic               ready;
  gpioe_pkg::op_t     operation;
  gpioe_pkg::addr_t   reg_address;
  logic [7:0]         write_byte;
  gpioe_pkg::pins_t   pin_levels;

  modport source (output valid, operation, reg_address, write_byte, pin_levels, input ready);
  modport sink   (input valid, operation, reg_address, write_byte, pin_levels, output ready);
endinterface

interface gpioe_rsp_if;
  logic               valid;
  logic               ready;
  logic [7:0]         read_byte;
  logic               irq_active;
  gpioe_pkg::pins_t   drive_enable;
  gpioe_pkg::pins_t   drive_level;

  modport source (output valid, read_byte, irq_active, drive_enable, drive_level, input ready);
  modport sink   (input valid, read_byte, irq_active, drive_enable, drive_level, output ready);
endinterface

### sv/gpioe_regs.sv
// Register file, reset-key sequence and edge detection of the GPIO expander.
// Depends on gpioe_pkg.
module gpioe_regs #(
  parameter int unsigned NUM_PINS = gpioe_pkg::NUM_PINS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  gpioe_pkg::item_t   item,
  output gpioe_pkg::result_t result
);

  localparam int unsigned W = gpioe_pkg::PIN_WIDTH;
  localparam logic [W-1:0] PinMask = W'((33'd1 << NUM_PINS) - 33'd1);

  logic [W-1:0]   direction_bits, direction_bits_next;
  logic [W-1:0]   pullup_bits, pullup_bits_next;
  logic [W-1:0]   output_latch, output_latch_next;
  logic [W-1:0]   mask_bits, mask_bits_next;
  logic [2*W-1:0] sense_codes, sense_codes_next;
  logic [W-1:0]   source_bits, source_bits_next;
  logic [W-1:0]   event_bits, event_bits_next;
  logic [W-1:0]   previous_levels, previous_levels_next;
  logic           reset_armed, reset_armed_next;

  logic [W-1:0] data_word, prev_w, src_w, evt_w, rise, fall, edges;
  logic [W-1:0] clr;
  logic [7:0]   rd_byte;
  logic         restore;

  always_comb begin
    data_word = ((direction_bits & item.pin_levels) | (~direction_bits & output_latch)) & PinMask;

    rd_byte = 8'h00;
    if (item.operation == gpioe_pkg::OP_READ) begin
      case (item.reg_address)
        gpioe_pkg::ADDR_PULLUP_B: rd_byte = pullup_bits[15:8];
        gpioe_pkg::ADDR_PULLUP_A: rd_byte = pullup_bits[7:0];
        gpioe_pkg::ADDR_DIR_B:    rd_byte = direction_bits[15:8];
        gpioe_pkg::ADDR_DIR_A:    rd_byte = direction_bits[7:0];
        gpioe_pkg::ADDR_DATA_B:   rd_byte = data_word[15:8];
        gpioe_pkg::ADDR_DATA_A:   rd_byte = data_word[7:0];
        gpioe_pkg::ADDR_MASK_B:   rd_byte = mask_bits[15:8];
        gpioe_pkg::ADDR_MASK_A:   rd_byte = mask_bits[7:0];
        gpioe_pkg::ADDR_SENSE_3:  rd_byte = sense_codes[31:24];
        gpioe_pkg::ADDR_SENSE_2:  rd_byte = sense_codes[23:16];
        gpioe_pkg::ADDR_SENSE_1:  rd_byte = sense_codes[15:8];
        gpioe_pkg::ADDR_SENSE_0:  rd_byte = sense_codes[7:0];
        gpioe_pkg::ADDR_SOURCE_B: rd_byte = source_bits[15:8];
        gpioe_pkg::ADDR_SOURCE_A: rd_byte = source_bits[7:0];
        gpioe_pkg::ADDR_EVENT_B:  rd_byte = event_bits[15:8];
        gpioe_pkg::ADDR_EVENT_A:  rd_byte = event_bits[7:0];
        default:                  rd_byte = 8'h00;
      endcase
    end

    direction_bits_next = direction_bits;
    pullup_bits_next    = pullup_bits;
    output_latch_next   = output_latch;
    mask_bits_next      = mask_bits;
    sense_codes_next    = sense_codes;
    reset_armed_next    = reset_armed;
    clr                 = '0;
    restore             = 1'b0;

    if (item.operation == gpioe_pkg::OP_WRITE) begin
      case (item.reg_address)
        gpioe_pkg::ADDR_PULLUP_B: pullup_bits_next[15:8]    = item.write_byte;
        gpioe_pkg::ADDR_PULLUP_A: pullup_bits_next[7:0]     = item.write_byte;
        gpioe_pkg::ADDR_DIR_B:    direction_bits_next[15:8] = item.write_byte;
        gpioe_pkg::ADDR_DIR_A:    direction_bits_next[7:0]  = item.write_byte;
        gpioe_pkg::ADDR_DATA_B:   output_latch_next[15:8]   = item.write_byte;
        gpioe_pkg::ADDR_DATA_A:   output_latch_next[7:0]    = item.write_byte;
        gpioe_pkg::ADDR_MASK_B:   mask_bits_next[15:8]      = item.write_byte;
        gpioe_pkg::ADDR_MASK_A:   mask_bits_next[7:0]       = item.write_byte;
        gpioe_pkg::ADDR_SENSE_3:  sense_codes_next[31:24]   = item.write_byte;
        gpioe_pkg::ADDR_SENSE_2:  sense_codes_next[23:16]   = item.write_byte;
        gpioe_pkg::ADDR_SENSE_1:  sense_codes_next[15:8]    = item.write_byte;
        gpioe_pkg::ADDR_SENSE_0:  sense_codes_next[7:0]     = item.write_byte;
        gpioe_pkg::ADDR_SOURCE_B,
        gpioe_pkg::ADDR_EVENT_B:  clr[15:8]                 = item.write_byte;
        gpioe_pkg::ADDR_SOURCE_A,
        gpioe_pkg::ADDR_EVENT_A:  clr[7:0]                  = item.write_byte;
        gpioe_pkg::ADDR_RESET: begin
          if (item.write_byte == gpioe_pkg::RESET_KEY1) begin
            reset_armed_next = 1'b1;
          end else if (item.write_byte == gpioe_pkg::RESET_KEY2 && reset_armed) begin
            restore = 1'b1;
          end else begin
            reset_armed_next = 1'b0;
          end
        end
        default: ;
      endcase
    end

    src_w  = source_bits & ~clr;
    evt_w  = event_bits & ~clr;
    prev_w = previous_levels;
    if (restore) begin
      direction_bits_next = '1;
      pullup_bits_next    = '0;
      output_latch_next   = '1;
      mask_bits_next      = '1;
      sense_codes_next    = '0;
      reset_armed_next    = 1'b0;
      src_w               = '0;
      evt_w               = '0;
      prev_w              = '1;
    end

    rise = ~prev_w & item.pin_levels;
    fall = prev_w & ~item.pin_levels;
    for (int n = 0; n < W; n++) begin
      edges[n] = (sense_codes_next[2*n] & rise[n]) | (sense_codes_next[2*n+1] & fall[n]);
    end
    edges = edges & PinMask;

    event_bits_next      = evt_w | edges;
    source_bits_next     = src_w | (edges & ~mask_bits_next);
    previous_levels_next = item.pin_levels;

    result.read_byte    = rd_byte;
    result.irq_active   = |source_bits_next;
    result.drive_enable = ~direction_bits_next & PinMask;
    result.drive_level  = ~direction_bits_next & output_latch_next & PinMask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction_bits  <= '1;
      pullup_bits     <= '0;
      output_latch    <= '1;
      mask_bits       <= '1;
      sense_codes     <= '0;
      source_bits     <= '0;
      event_bits      <= '0;
      previous_levels <= '1;
      reset_armed     <= 1'b0;
    end else if (fire) begin
      direction_bits  <= direction_bits_next;
      pullup_bits     <= pullup_bits_next;
      output_latch    <= output_latch_next;
      mask_bits       <= mask_bits_next;
      sense_codes     <= sense_codes_next;
      source_bits     <= source_bits_next;
      event_bits      <= event_bits_next;
      previous_levels <= previous_levels_next;
      reset_armed     <= reset_armed_next;
    end
  end

endmodule

### sv/gpioe_outq.sv
// Two-entry result queue between the register block and the output channel.
// Depends on gpioe_pkg.
module gpioe_outq (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  gpioe_pkg::result_t push_data,
  input  logic               pop,
  output gpioe_pkg::result_t head,
  output gpioe_pkg::q_stat_t stat
);

  localparam int unsigned Depth = 2;

  gpioe_pkg::result_t entries [Depth];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign head       = entries[rd_ptr];
  assign stat.full  = (count == 2'(Depth));
  assign stat.empty = (count == 2'd0);

endmodule

### sv/gpio_expander_edge_interrupt_top.sv
// GPIO expander with edge interrupts: input register, register block, result queue.
// Depends on gpioe_pkg, gpioe_if, gpioe_regs, gpioe_outq and the defines header.
//
//   channel | dir | word
//   --------+-----+-------------------------------------------------------
//   req     | in  | operation, reg_address, write_byte, pin_levels
//   rsp     | out | read_byte, irq_active, drive_enable, drive_level
//
// One word per clock sustained while rsp takes results; a result is offered on rsp once
// the word has passed the input register and the register-block update into the queue.
// rst is synchronous; the register-block registers return to the register-map reset values.
// A stalled rsp fills the two-entry queue; req.ready drops only when the queue
// is full and the input register still holds a word.
`include "gpio_expander_edge_interrupt_top_defines.svh"

module gpio_expander_edge_interrupt_top #(
  parameter int unsigned NUM_PINS = gpioe_pkg::NUM_PINS_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  gpioe_req_if.sink  req,
  gpioe_rsp_if.source rsp
);

  gpioe_pkg::item_t   item_q;
  logic               item_valid;
  logic               adv;
  logic               pop;
  gpioe_pkg::result_t result;
  gpioe_pkg::result_t head;
  gpioe_pkg::q_stat_t stat;

  assign adv       = item_valid && !stat.full;
  assign req.ready = !item_valid || adv;
  assign pop       = rsp.valid && rsp.ready;

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item_q.operation   <= req.operation;
      item_q.reg_address <= req.reg_address;
      item_q.write_byte  <= req.write_byte;
      item_q.pin_levels  <= req.pin_levels;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      item_valid <= 1'b1;
    end else if (adv) begin
      item_valid <= 1'b0;
    end
  end

  gpioe_regs #(
    .NUM_PINS(NUM_PINS)
  ) u_regs (
    .clk    (clk),
    .rst    (rst),
    .fire   (adv),
    .item   (item_q),
    .result (result)
  );

  gpioe_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (adv),
    .push_data (result),
    .pop       (pop),
    .head      (head),
    .stat      (stat)
  );

  assign rsp.valid        = !stat.empty;
  assign rsp.read_byte    = head.read_byte;
  assign rsp.irq_active   = head.irq_active;
  assign rsp.drive_enable = head.drive_enable;
  assign rsp.drive_level  = head.drive_level;

  `GPIOE_ASSERT_NOW(a_no_overflow, adv, !stat.full, "push into full result queue")
  `GPIOE_ASSERT_NOW(a_drive_in_enable, rsp.valid, (rsp.drive_level & ~rsp.drive_enable) == 16'h0, "drive level on input pin")
  `GPIOE_ASSERT_NEXT(a_hold_stalled, item_valid && !adv, item_valid, "stalled input word lost")
  `GPIOE_ASSERT_NEXT(a_push_shows, adv, rsp.valid, "pushed result not visible")

endmodule

### tb/tb_gpio_expander_edge_interrupt_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for gpio_expander_edge_interrupt_top: random and directed words
// on req, results on rsp compared with an in-bench model of the register block.
// Depends on gpioe_pkg, gpioe_if and the DUT sources.
module tb_gpio_expander_edge_interrupt_top;

  localparam gpioe_pkg::op_t   OP_UNUSED     = 2'd3;
  localparam gpioe_pkg::addr_t ADDR_UNMAPPED = 7'h7f;

  typedef struct {
    gpioe_pkg::item_t word;
    bit               drain;
  } stim_t;

  logic clk;
  logic rst;

  gpioe_req_if req_ch ();
  gpioe_rsp_if rsp_ch ();

  gpio_expander_edge_interrupt_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  stim_t              stim_words[$];
  gpioe_pkg::result_t predicted_outputs[$];
  int      errors = 0;
  int      n_reads = 0, n_writes = 0, n_key_resets = 0, n_irq_seen = 0, n_results = 0;

  // model state
  gpioe_pkg::pins_t dir_r, pull_r, latch_r, mask_r, src_r, evt_r, prev_r;
  logic [31:0]      sense_r;
  bit               armed_r;

  function automatic void restore_regs();
    dir_r   = '1;
    pull_r  = '0;
    latch_r = '1;
    mask_r  = '1;
    sense_r = '0;
    src_r   = '0;
    evt_r   = '0;
    prev_r  = '1;
    armed_r = 1'b0;
  endfunction

  function automatic gpioe_pkg::result_t expander_update(gpioe_pkg::item_t w);
    gpioe_pkg::result_t r;
    gpioe_pkg::pins_t   data, rise, fall, edges, clr;
    r    = '0;
    data = (dir_r & w.pin_levels) | (~dir_r & latch_r);
    if (w.operation == gpioe_pkg::OP_READ) begin
      n_reads++;
      case (w.reg_address)
        gpioe_pkg::ADDR_PULLUP_B: r.read_byte = pull_r[15:8];
        gpioe_pkg::ADDR_PULLUP_A: r.read_byte = pull_r[7:0];
        gpioe_pkg::ADDR_DIR_B:    r.read_byte = dir_r[15:8];
        gpioe_pkg::ADDR_DIR_A:    r.read_byte = dir_r[7:0];
        gpioe_pkg::ADDR_DATA_B:   r.read_byte = data[15:8];
        gpioe_pkg::ADDR_DATA_A:   r.read_byte = data[7:0];
        gpioe_pkg::ADDR_MASK_B:   r.read_byte = mask_r[15:8];
        gpioe_pkg::ADDR_MASK_A:   r.read_byte = mask_r[7:0];
        gpioe_pkg::ADDR_SENSE_3:  r.read_byte = sense_r[31:24];
        gpioe_pkg::ADDR_SENSE_2:  r.read_byte = sense_r[23:16];
        gpioe_pkg::ADDR_SENSE_1:  r.read_byte = sense_r[15:8];
        gpioe_pkg::ADDR_SENSE_0:  r.read_byte = sense_r[7:0];
        gpioe_pkg::ADDR_SOURCE_B: r.read_byte = src_r[15:8];
        gpioe_pkg::ADDR_SOURCE_A: r.read_byte = src_r[7:0];
        gpioe_pkg::ADDR_EVENT_B:  r.read_byte = evt_r[15:8];
        gpioe_pkg::ADDR_EVENT_A:  r.read_byte = evt_r[7:0];
        default:                  r.read_byte = 8'h00;
      endcase
    end else if (w.operation == gpioe_pkg::OP_WRITE) begin
      n_writes++;
      clr = '0;
      case (w.reg_address)
        gpioe_pkg::ADDR_PULLUP_B: pull_r[15:8]    = w.write_byte;
        gpioe_pkg::ADDR_PULLUP_A: pull_r[7:0]     = w.write_byte;
        gpioe_pkg::ADDR_DIR_B:    dir_r[15:8]     = w.write_byte;
        gpioe_pkg::ADDR_DIR_A:    dir_r[7:0]      = w.write_byte;
        gpioe_pkg::ADDR_DATA_B:   latch_r[15:8]   = w.write_byte;
        gpioe_pkg::ADDR_DATA_A:   latch_r[7:0]    = w.write_byte;
        gpioe_pkg::ADDR_MASK_B:   mask_r[15:8]    = w.write_byte;
        gpioe_pkg::ADDR_MASK_A:   mask_r[7:0]     = w.write_byte;
        gpioe_pkg::ADDR_SENSE_3:  sense_r[31:24]  = w.write_byte;
        gpioe_pkg::ADDR_SENSE_2:  sense_r[23:16]  = w.write_byte;
        gpioe_pkg::ADDR_SENSE_1:  sense_r[15:8]   = w.write_byte;
        gpioe_pkg::ADDR_SENSE_0:  sense_r[7:0]    = w.write_byte;
        gpioe_pkg::ADDR_SOURCE_B, gpioe_pkg::ADDR_EVENT_B: clr[15:8] = w.write_byte;
        gpioe_pkg::ADDR_SOURCE_A, gpioe_pkg::ADDR_EVENT_A: clr[7:0]  = w.write_byte;
        gpioe_pkg::ADDR_RESET: begin
          if (w.write_byte == gpioe_pkg::RESET_KEY1) begin
            armed_r = 1'b1;
          end else if (w.write_byte == gpioe_pkg::RESET_KEY2 && armed_r) begin
            restore_regs();
            n_key_resets++;
          end else begin
            armed_r = 1'b0;
          end
        end
        default: ;
      endcase
      src_r = src_r & ~clr;
      evt_r = evt_r & ~clr;
    end
    rise  = ~prev_r & w.pin_levels;
    fall  = prev_r & ~w.pin_levels;
    edges = '0;
    for (int n = 0; n < 16; n++)
      edges[n] = (sense_r[2*n] & rise[n]) | (sense_r[2*n+1] & fall[n]);
    evt_r  = evt_r | edges;
    src_r  = src_r | (edges & ~mask_r);
    prev_r = w.pin_levels;
    r.irq_active   = |src_r;
    r.drive_enable = ~dir_r;
    r.drive_level  = ~dir_r & latch_r;
    return r;
  endfunction

  function automatic int gap_pick();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always #5 clk = ~clk;

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.operation   = gpioe_pkg::OP_SAMPLE;
    req_ch.reg_address = '0;
    req_ch.write_byte  = '0;
    req_ch.pin_levels  = '0;
    rsp_ch.ready       = 1'b0;
    restore_regs();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // driver
  int               send_gap = 0, send_calm_left = 0;
  bit               send_calm = 0;
  stim_t            cur;
  gpioe_pkg::item_t acc;

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        acc = {req_ch.operation, req_ch.reg_address, req_ch.write_byte, req_ch.pin_levels};
        predicted_outputs.push_back(expander_update(acc));
      end
      if (req_ch.valid && !req_ch.ready) begin
        // hold the word
      end else if (send_gap != 0) begin
        send_gap--;
        req_ch.valid <= 1'b0;
      end else if (stim_words.size() != 0 &&
                   !(stim_words[0].drain && predicted_outputs.size() != 0)) begin
        cur = stim_words.pop_front();
        req_ch.operation   <= cur.word.operation;
        req_ch.reg_address <= cur.word.reg_address;
        req_ch.write_byte  <= cur.word.write_byte;
        req_ch.pin_levels  <= cur.word.pin_levels;
        req_ch.valid       <= 1'b1;
        if (send_calm_left == 0) begin
          send_calm      = ($urandom_range(0, 3) == 0);
          send_calm_left = $urandom_range(20, 80);
        end
        send_calm_left--;
        send_gap = send_calm ? 0 : gap_pick();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // receiver ready, with two long hold-offs
  int recv_gap = 0, recv_calm_left = 0, hold_left = 0, cycle_count = 0;
  bit recv_calm = 0;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      cycle_count++;
      if (cycle_count == 400 || cycle_count == 1500) hold_left = 120;
      if (hold_left != 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (recv_calm_left == 0) begin
          recv_calm      = ($urandom_range(0, 3) == 0);
          recv_calm_left = $urandom_range(20, 80);
        end
        recv_calm_left--;
        recv_gap = recv_calm ? 0 : gap_pick();
      end
    end
  end

  // monitor
  gpioe_pkg::result_t exp_r;

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      n_results++;
      if (predicted_outputs.size() == 0) begin
        $error("result word with no prediction pending");
        errors++;
      end else begin
        exp_r = predicted_outputs.pop_front();
        if (exp_r.irq_active) n_irq_seen++;
        if (rsp_ch.read_byte !== exp_r.read_byte) begin
          $error("read_byte: expected %h, got %h", exp_r.read_byte, rsp_ch.read_byte);
          errors++;
        end
        if (rsp_ch.irq_active !== exp_r.irq_active) begin
          $error("irq_active: expected %b, got %b", exp_r.irq_active, rsp_ch.irq_active);
          errors++;
        end
        if (rsp_ch.drive_enable !== exp_r.drive_enable) begin
          $error("drive_enable: expected %h, got %h", exp_r.drive_enable, rsp_ch.drive_enable);
          errors++;
        end
        if (rsp_ch.drive_level !== exp_r.drive_level) begin
          $error("drive_level: expected %h, got %h", exp_r.drive_level, rsp_ch.drive_level);
          errors++;
        end
      end
    end
  end

  // stimulus
  gpioe_pkg::pins_t last_pins = '1;
  gpioe_pkg::addr_t addr_map[17] = '{
    gpioe_pkg::ADDR_PULLUP_B, gpioe_pkg::ADDR_PULLUP_A, gpioe_pkg::ADDR_DIR_B,
    gpioe_pkg::ADDR_DIR_A, gpioe_pkg::ADDR_DATA_B, gpioe_pkg::ADDR_DATA_A,
    gpioe_pkg::ADDR_MASK_B, gpioe_pkg::ADDR_MASK_A, gpioe_pkg::ADDR_SENSE_3,
    gpioe_pkg::ADDR_SENSE_2, gpioe_pkg::ADDR_SENSE_1, gpioe_pkg::ADDR_SENSE_0,
    gpioe_pkg::ADDR_SOURCE_B, gpioe_pkg::ADDR_SOURCE_A, gpioe_pkg::ADDR_EVENT_B,
    gpioe_pkg::ADDR_EVENT_A, gpioe_pkg::ADDR_RESET};

  task automatic push_word(gpioe_pkg::op_t op, gpioe_pkg::addr_t a, logic [7:0] b,
                           gpioe_pkg::pins_t p, bit drain);
    stim_t s;
    s.word.operation   = op;
    s.word.reg_address = a;
    s.word.write_byte  = b;
    s.word.pin_levels  = p;
    s.drain            = drain;
    stim_words.push_back(s);
  endtask

  function automatic gpioe_pkg::pins_t next_pins();
    gpioe_pkg::pins_t p;
    if ($urandom_range(0, 1) == 0) p = gpioe_pkg::pins_t'($urandom_range(0, 16'hffff));
    else p = last_pins ^ (gpioe_pkg::pins_t'(1) << $urandom_range(0, 15))
                       ^ (gpioe_pkg::pins_t'($urandom_range(0, 1)) << $urandom_range(0, 15));
    last_pins = p;
    return p;
  endfunction

  initial begin : stim
    int               k;
    gpioe_pkg::op_t   op;
    gpioe_pkg::addr_t a;
    bit               drain;

    push_word(gpioe_pkg::OP_READ,   gpioe_pkg::ADDR_DIR_A,    8'h00, 16'hffff, 1'b0);
    push_word(gpioe_pkg::OP_WRITE,  gpioe_pkg::ADDR_SENSE_0,  8'hff, 16'hffff, 1'b0);
    push_word(gpioe_pkg::OP_WRITE,  gpioe_pkg::ADDR_SENSE_3,  8'hff, 16'hffff, 1'b0);
    push_word(gpioe_pkg::OP_WRITE,  gpioe_pkg::ADDR_MASK_A,   8'h00, 16'hffff, 1'b0);
    push_word(gpioe_pkg::OP_SAMPLE, gpioe_pkg::ADDR_DIR_A,    8'h00, 16'h0000, 1'b0);
    push_word(gpioe_pkg::OP_READ,   gpioe_pkg::ADDR_SOURCE_A, 8'h00, 16'h0000, 1'b0);
    push_word(gpioe_pkg::OP_READ,   gpioe_pkg::ADDR_EVENT_B,  8'h00, 16'h0000, 1'b0);
    // clear while the same word sets: set wins
    push_word(gpioe_pkg::OP_WRITE,  gpioe_pkg::ADDR_SOURCE_A, 8'hff, 16'h000f, 1'b0);
    push_word(gpioe_pkg::OP_WRITE,  gpioe_pkg::ADDR_EVENT_B,  8'hff, 16'h000f, 1'b0);
    push_word(gpioe_pkg::OP_WRITE,  gpioe_pkg::ADDR_DIR_A,    8'h00, 16'h000f, 1'b0);
    push_word(gpioe_pkg::OP_WRITE,  gpioe_pkg::ADDR_DATA_A,   8'ha5, 16'h000f, 1'b0);
    push_word(gpioe_pkg::OP_READ,   gpioe_pkg::ADDR_DATA_A,   8'h00, 16'h5a5a, 1'b0);
    push_word(gpioe_pkg::OP_READ,   gpioe_pkg::ADDR_DATA_B,   8'h00, 16'h5a5a, 1'b0);
    push_word(gpioe_pkg::OP_WRITE,  gpioe_pkg::ADDR_PULLUP_B, 8'hff, 16'hffff, 1'b0);
    push_word(gpioe_pkg::OP_READ,   gpioe_pkg::ADDR_PULLUP_B, 8'h00, 16'hffff, 1'b0);
    push_word(gpioe_pkg::OP_READ,   ADDR_UNMAPPED,            8'hff, 16'h0000, 1'b0);
    push_word(gpioe_pkg::OP_WRITE,  ADDR_UNMAPPED,            8'h55, 16'hffff, 1'b0);
    push_word(OP_UNUSED,            gpioe_pkg::ADDR_DIR_A,    8'hff, 16'h0000, 1'b0);
    // key sequence: unarmed key2, armed with an unrelated write between, disarm
    push_word(gpioe_pkg::OP_WRITE, gpioe_pkg::ADDR_RESET, gpioe_pkg::RESET_KEY2, 16'hffff, 1'b0);
    push_word(gpioe_pkg::OP_WRITE, gpioe_pkg::ADDR_RESET, gpioe_pkg::RESET_KEY1, 16'h00ff, 1'b0);
    push_word(gpioe_pkg::OP_WRITE, gpioe_pkg::ADDR_DIR_B, 8'h00,                 16'hff00, 1'b0);
    push_word(gpioe_pkg::OP_WRITE, gpioe_pkg::ADDR_RESET, gpioe_pkg::RESET_KEY2, 16'h0000, 1'b0);
    push_word(gpioe_pkg::OP_WRITE, gpioe_pkg::ADDR_RESET, gpioe_pkg::RESET_KEY1, 16'h0000, 1'b0);
    push_word(gpioe_pkg::OP_WRITE, gpioe_pkg::ADDR_RESET, 8'h00,                 16'h0000, 1'b0);
    push_word(gpioe_pkg::OP_WRITE, gpioe_pkg::ADDR_RESET, gpioe_pkg::RESET_KEY2, 16'h0000, 1'b0);
    push_word(gpioe_pkg::OP_READ,  gpioe_pkg::ADDR_RESET, 8'h00,                 16'hffff, 1'b0);
    last_pins = 16'hffff;

    for (int i = 0; i < 1825; i++) begin
      drain = (i % 450 == 0);
      k = $urandom_range(0, 99);
      if (k < 3) begin
        push_word(gpioe_pkg::OP_WRITE, gpioe_pkg::ADDR_RESET, gpioe_pkg::RESET_KEY1,
                  next_pins(), drain);
        push_word(gpioe_pkg::OP_WRITE, gpioe_pkg::ADDR_RESET, gpioe_pkg::RESET_KEY2,
                  next_pins(), 1'b0);
        i++;
      end else begin
        if (k < 6) op = OP_UNUSED;
        else if (k < 28) op = gpioe_pkg::OP_SAMPLE;
        else if (k < 62) op = gpioe_pkg::OP_WRITE;
        else op = gpioe_pkg::OP_READ;
        if ($urandom_range(0, 9) == 0) a = gpioe_pkg::addr_t'($urandom_range(0, 127));
        else a = addr_map[$urandom_range(0, 16)];
        push_word(op, a, 8'($urandom_range(0, 255)), next_pins(), drain);
      end
    end

    while (stim_words.size() != 0 || req_ch.valid) @(posedge clk);
    while (predicted_outputs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("covered %0d words: %0d reads, %0d writes, %0d key resets, %0d with irq high",
             n_results, n_reads, n_writes, n_key_resets, n_irq_seen);
    if (errors == 0) begin
      $display("gpio_expander_edge_interrupt_top: match");
    end else begin
      $display("gpio_expander_edge_interrupt_top: mismatch");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("gpio_expander_edge_interrupt_top: mismatch");
    $finish;
  end

endmodule
